### rtl/core/sabs_pkg.sv
// Shared constants, codes and types of the sorted array binary search block.
package sabs_pkg;

	// Store geometry.
	localparam int STORE_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int BND_W       = IDX_W + 2;

	// Result field widths, fixed by the port list.
	localparam int MATCH_W = 10;
	localparam int PROBE_W = 4;
	localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

	// Command codes.
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} sabs_op_t;

	// Search sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} sabs_state_t;

	// One search result word.
	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   index;
		logic [PROBE_W-1:0] probes;
	} sabs_result_t;

endpackage

### rtl/core/sabs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sabs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/sabs_search.sv
// Binary search sequencer: one store probe per cycle against the registered read data.
module sabs_search import sabs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic signed [DATA_W-1:0] key,
	input  logic [CNT_W-1:0]         count,
	input  logic [DATA_W-1:0]        rd_data,
	output logic                     rd_en,
	output logic [IDX_W-1:0]         rd_addr,
	output logic                     busy,
	output logic                     res_valid,
	output sabs_result_t             res
);

	sabs_state_t              state_q, state_d;
	logic signed [BND_W-1:0]  lo_q, hi_q, lo_n, hi_n, mid_ext;
	logic [IDX_W-1:0]         mid_q, mid0, mid_n;
	logic signed [DATA_W-1:0] key_q, elem;
	logic [PROBE_W-1:0]       probes_q, probes_n;
	logic                     hit, go_right, more, empty;
	logic                     res_load;
	sabs_result_t             res_d, res_q;
	logic                     res_valid_q;

	// Probe datapath: compare the element read at mid and narrow the bounds.
	always_comb begin
		elem     = $signed(rd_data);
		hit      = (elem == key_q);
		go_right = (key_q > elem);
		mid_ext  = $signed({2'b00, mid_q});
		lo_n     = go_right ? mid_ext + BND_W'(1) : lo_q;
		hi_n     = go_right ? hi_q : mid_ext - BND_W'(1);
		more     = (lo_n <= hi_n);
		mid_n    = IDX_W'(lo_n + ((hi_n - lo_n) >>> 1));
		probes_n = (probes_q == PROBE_MAX) ? probes_q : probes_q + PROBE_W'(1);
		empty    = (count == '0);
		mid0     = IDX_W'((count - CNT_W'(1)) >> 1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (go && !empty) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (hit || !more) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory read request and result capture.
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = mid0;
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					rd_en    = !empty;
					res_load = empty;
				end
			end
			ST_PROBE: begin
				res_d.probes = probes_n;
				if (hit) begin
					res_load    = 1'b1;
					res_d.found = 1'b1;
					res_d.index = mid_q;
				end else if (more) begin
					rd_en   = 1'b1;
					rd_addr = mid_n;
				end else begin
					res_load = 1'b1;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_load;
		end
	end

	// Bounds, key, probe count and the result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lo_q     <= '0;
			hi_q     <= $signed({1'b0, count}) - BND_W'(1);
			mid_q    <= mid0;
			key_q    <= key;
			probes_q <= '0;
		end else begin
			lo_q     <= lo_n;
			hi_q     <= hi_n;
			mid_q    <= mid_n;
			probes_q <= probes_n;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A result appears only after a probe cycle or a search of an empty store.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(state_q == ST_PROBE || (go && empty)))
		else $error("result without a search");

	// A hit always costs at least one probe.
	a_hit_probes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.found |-> res_q.probes != '0)
		else $error("hit with zero probes");

	// While probing, the window is non-empty and lies inside the filled part.
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> (lo_q <= hi_q) && (hi_q < $signed({1'b0, count})))
		else $error("search window out of range");

	// Every probe cycle is fed by a read issued in the cycle before.
	a_read_fed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> $past(rd_en))
		else $error("probe without a preceding read");

endmodule

### rtl/core/sorted_array_binary_search.sv
// Top level of the sorted array binary search block: command decode, fill count and store.
//
//  Channel   Signals                                    Direction  Handshake
//  command   start, busy, opcode, operand_value         in         start && !busy
//  result    strobe, found, match_index, probe_count    out        strobe, one cycle
//
// Clear and append give no word; a new command may follow at once.
// A search of n stored elements makes p <= log2(n) + 1 probes, as the read port of the
// store is registered: each probe compares the element read in the cycle before.
// The result word shows in the cycle after the last probe; a search of an empty store
// shows its word in the cycle after acceptance. busy is high while probing.
// Reset clears the fill count and the sequencer; the store contents need no reset.
// The receiver cannot stall, so results are never held back.
module sorted_array_binary_search import sabs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] operand_value,
	output logic                     strobe,
	output logic                     found,
	output logic [MATCH_W-1:0]       match_index,
	output logic [PROBE_W-1:0]       probe_count
);

	logic [CNT_W-1:0]  count_q;
	logic              accept, do_clear, do_append, do_search;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;
	sabs_result_t      res;

	// Command decode; an append to a full store is dropped.
	always_comb begin
		accept    = start && !busy;
		do_clear  = accept && (sabs_op_t'(opcode) == OP_CLEAR);
		do_append = accept && (sabs_op_t'(opcode) == OP_APPEND)
			&& (count_q != CNT_W'(STORE_DEPTH));
		do_search = accept && (sabs_op_t'(opcode) == OP_SEARCH);
	end

	// Fill count of the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_clear) begin
			count_q <= '0;
		end else if (do_append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Element store; appends and probes never overlap since busy blocks commands.
	sabs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_append),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (operand_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Search sequencer.
	sabs_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (do_search),
		.key       (operand_value),
		.count     (count_q),
		.rd_data   (rd_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.busy      (busy),
		.res_valid (strobe),
		.res       (res)
	);

	assign found       = res.found;
	assign match_index = MATCH_W'(res.index);
	assign probe_count = res.probes;

endmodule

### tb/sabs_search_checker.sv
// Checker for the sorted array binary search block: shadow store, search prediction, compare.
module sabs_search_checker import sabs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] operand_value,
	input  logic                     strobe,
	input  logic                     found,
	input  logic [MATCH_W-1:0]       match_index,
	input  logic [PROBE_W-1:0]       probe_count,
	output int                       mismatches,
	output int                       results_due
);

	// Shadow copy of the element store and its fill count.
	logic signed [DATA_W-1:0] shadow_store [STORE_DEPTH];
	int unsigned              shadow_count;

	// Predicted search words, oldest first.
	sabs_result_t search_words_due[$];

	// Walk the shadow store the same way the block does and count every probe.
	function automatic sabs_result_t predict_search(input logic signed [DATA_W-1:0] key);
		int           lo;
		int           hi;
		int           mid;
		int unsigned  probes;
		sabs_result_t word;
		word   = '0;
		lo     = 0;
		hi     = int'(shadow_count) - 1;
		probes = 0;
		while (lo <= hi && !word.found) begin
			mid = lo + (hi - lo) / 2;
			if (probes < PROBE_MAX)
				probes++;
			if (shadow_store[mid] == key) begin
				word.found = 1'b1;
				word.index = mid[IDX_W-1:0];
			end else if (key > shadow_store[mid]) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		word.probes = probes[PROBE_W-1:0];
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sabs_result_t due;
		if (!arst_n) begin
			shadow_count = 0;
			search_words_due.delete();
			mismatches  <= 0;
			results_due <= 0;
		end else begin
			// A result word is held against the oldest search still due.
			if (strobe) begin
				if (search_words_due.size() == 0) begin
					$display("%0t: unexpected search word: found=%0d index=%0d probes=%0d",
						$time, found, match_index, probe_count);
					mismatches <= mismatches + 1;
				end else begin
					due = search_words_due.pop_front();
					if (due.found !== found || due.index !== match_index ||
							due.probes !== probe_count) begin
						$display("%0t: search word mismatch: expected found=%0d index=%0d probes=%0d",
							$time, due.found, due.index, due.probes);
						$display("%0t:                       actual   found=%0d index=%0d probes=%0d",
							$time, found, match_index, probe_count);
						mismatches <= mismatches + 1;
					end
				end
			end

			// An accepted command updates the shadow store or queues a prediction.
			if (start && !busy) begin
				case (sabs_op_t'(opcode))
				OP_CLEAR: begin
					shadow_count = 0;
				end
				OP_APPEND: begin
					if (shadow_count < STORE_DEPTH) begin
						shadow_store[shadow_count] = operand_value;
						shadow_count++;
					end
				end
				OP_SEARCH: begin
					search_words_due.insert(search_words_due.size(),
						predict_search(operand_value));
				end
				default: begin
				end
				endcase
			end
			results_due <= search_words_due.size();
		end
	end

endmodule

### tb/testbench.sv
// Top of the sorted array binary search testbench: clock, reset, command stimulus and verdict.
module testbench;
	import sabs_pkg::*;

	localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	// Ways to fill the store: spread ascending, dense ascending with repeats, or out of order.
	typedef enum {SPREAD, NARROW, UNSORTED} fill_shape_t;

	logic                     clk;
	logic                     arst_n        = 1'b0;
	logic                     start         = 1'b0;
	logic [1:0]               opcode        = OP_NONE;
	logic signed [DATA_W-1:0] operand_value = '0;
	logic                     busy;
	logic                     strobe;
	logic                     found;
	logic [MATCH_W-1:0]       match_index;
	logic [PROBE_W-1:0]       probe_count;
	int                       mismatches;
	int                       results_due;

	int                       idle_pct      = 0;
	int                       commands_sent = 0;
	logic signed [DATA_W-1:0] loaded_values[$];

	sorted_array_binary_search DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.operand_value (operand_value),
		.strobe        (strobe),
		.found         (found),
		.match_index   (match_index),
		.probe_count   (probe_count)
	);

	sabs_search_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.operand_value (operand_value),
		.strobe        (strobe),
		.found         (found),
		.match_index   (match_index),
		.probe_count   (probe_count),
		.mismatches    (mismatches),
		.results_due   (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

	// Send one command word and wait until the block takes it.
	task automatic issue(input sabs_op_t op, input logic signed [DATA_W-1:0] value);
		start         <= 1'b1;
		opcode        <= op;
		operand_value <= value;
		do @(posedge clk); while (busy);
		if (op != OP_NONE)
			commands_sent++;
		// Random sender gap; the payload carries junk while start is low.
		if ($urandom_range(99) < idle_pct) begin
			start         <= 1'b0;
			opcode        <= 2'($urandom);
			operand_value <= $urandom;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Hold off the sender until every search word has come back.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	// Append a run of values of the given shape, with the odd ignored opcode mixed in.
	task automatic load_values(input int count, input fill_shape_t shape);
		longint                   level;
		longint unsigned          stride;
		logic signed [DATA_W-1:0] value;
		stride = 64'hFFFF_FFFF / (count + 1);
		level  = longint'(KEY_MIN);
		for (int i = 0; i < count; i++) begin
			case (shape)
			SPREAD: begin
				level = level + $urandom_range(stride, (i == 0) ? 0 : 1);
			end
			NARROW: begin
				level = (i == 0) ? longint'($urandom_range(10)) - 5 : level + $urandom_range(2);
			end
			default: begin
				level = longint'($signed($urandom));
			end
			endcase
			value = level[DATA_W-1:0];
			loaded_values.insert(loaded_values.size(), value);
			issue(OP_APPEND, value);
			if ($urandom_range(99) < 3)
				issue(OP_NONE, $urandom);
		end
	endtask

	// Search key: mostly stored values, their neighbors, random keys and the extremes.
	function automatic logic signed [DATA_W-1:0] pick_key();
		int                       r;
		logic signed [DATA_W-1:0] member;
		r = $urandom_range(99);
		if (r >= 93)
			return KEY_MAX;
		if (r >= 85)
			return KEY_MIN;
		if (loaded_values.size() == 0 || r >= 70)
			return $urandom;
		member = loaded_values[$urandom_range(loaded_values.size() - 1)];
		if (r >= 50)
			return $urandom_range(1) ? member + 1 : member - 1;
		return member;
	endfunction

	// One random store load followed by a handful of searches.
	task automatic probe_random_set();
		int          r;
		int          count;
		fill_shape_t shape;
		r     = $urandom_range(99);
		count = (r < 5) ? 0 : (r < 85) ? $urandom_range(24, 1) : $urandom_range(200, 25);
		r     = $urandom_range(99);
		shape = (r < 70) ? SPREAD : (r < 85) ? NARROW : UNSORTED;
		// Now and then the store is extended rather than refilled.
		if ($urandom_range(99) >= 8) begin
			issue(OP_CLEAR, $urandom);
			loaded_values.delete();
		end
		load_values(count, shape);
		repeat ($urandom_range(6, 1))
			issue(OP_SEARCH, pick_key());
		if ($urandom_range(99) < 15)
			drain_results();
	endtask

	initial begin : stimulus
		int phase_pct[4] = '{0, 88, 0, 11};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty store, ignored opcode, extreme values, one-element store, disorder.
		issue(OP_SEARCH, '0);
		issue(OP_SEARCH, KEY_MIN);
		issue(OP_NONE, -1);
		issue(OP_APPEND, KEY_MIN);
		issue(OP_APPEND, -1);
		issue(OP_APPEND, 0);
		issue(OP_APPEND, KEY_MAX);
		issue(OP_SEARCH, KEY_MIN);
		issue(OP_SEARCH, -1);
		issue(OP_SEARCH, 0);
		issue(OP_SEARCH, KEY_MAX);
		issue(OP_SEARCH, 5);
		issue(OP_SEARCH, -5);
		issue(OP_CLEAR, -1);
		issue(OP_SEARCH, 0);
		issue(OP_APPEND, 7);
		issue(OP_SEARCH, 7);
		// Key below the only element drives the high bound under index zero.
		issue(OP_SEARCH, 3);
		issue(OP_SEARCH, 9);
		issue(OP_APPEND, 5);
		issue(OP_APPEND, 1);
		issue(OP_SEARCH, 1);
		issue(OP_SEARCH, 5);
		drain_results();

		// Random loads and searches under each sender idling pattern.
		foreach (phase_pct[p]) begin
			idle_pct      = phase_pct[p];
			commands_sent = 0;
			while (commands_sent < 75)
				probe_random_set();
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
